>>> sv/scld_pkg.sv
package scld_pkg;

	// default sizing
	localparam int LINE_BYTES_DEF  = 64;
	localparam int QUEUE_DEPTH_DEF = 2;

	// line head kept in flops: longest keyword plus the byte after it
	localparam int HEAD_BYTES = 8;

	// level register reset
	localparam logic [7:0] LEVEL_RESET = 8'd16;

	// control characters
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DEL   = 8'h7F;

	// result kinds
	typedef enum logic [1:0] {
		KIND_ECHO    = 2'd0,
		KIND_COLOUR  = 2'd1,
		KIND_UNKNOWN = 2'd2
	} kind_t;

	// classified word passed from front to back
	typedef enum logic [1:0] {
		OP_CHAR  = 2'd0,
		OP_EOL   = 2'd1,
		OP_BS    = 2'd2,
		OP_FLUSH = 2'd3
	} op_cls_t;

	typedef struct packed {
		op_cls_t    cls;
		logic [7:0] data;
	} op_t;

	// first bytes of the line, byte 0 in the low lane
	typedef logic [HEAD_BYTES-1:0][7:0] line_head_t;

	// keywords, written back to front so that byte 0 lands in the low lane
	localparam line_head_t KW_ON    = {16'h0, "NO_DEL"};
	localparam line_head_t KW_OFF   = {8'h0, "FFO_DEL"};
	localparam line_head_t KW_RED   = {40'h0, "DER"};
	localparam line_head_t KW_GREEN = {24'h0, "NEERG"};
	localparam line_head_t KW_BLUE  = {32'h0, "EULB"};

	localparam logic [3:0] KW_ON_LEN    = 4'd6;
	localparam logic [3:0] KW_OFF_LEN   = 4'd7;
	localparam logic [3:0] KW_RED_LEN   = 4'd3;
	localparam logic [3:0] KW_GREEN_LEN = 4'd5;
	localparam logic [3:0] KW_BLUE_LEN  = 4'd4;

	// line (cut at its first zero) equals keyword; len_sat is length capped at HEAD_BYTES
	function automatic logic kw_hit(input line_head_t head, input line_head_t kw,
			input logic [3:0] klen, input logic [3:0] len_sat);
		logic hit;
		hit = (len_sat >= klen);
		for (int i = 0; i < HEAD_BYTES; i++) begin
			if (4'(i) < klen && head[i] != kw[i])
				hit = 1'b0;
			// a longer line only matches if it stops at a zero right after the keyword
			if (4'(i) == klen && len_sat > klen && head[i] != 8'h00)
				hit = 1'b0;
		end
		return hit;
	endfunction

endpackage

>>> sv/scld_if.sv
// input channel: one received byte or a flush
interface scld_item_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] rx_byte;

	modport source (output valid, output cmd, output rx_byte, input ready);
	modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

// result channel: echo byte, colour or unknown-command flag
interface scld_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] tx_byte;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       last;

	modport source (output valid, output kind, output tx_byte, output red, output green,
		output blue, output last, input ready);
	modport sink (input valid, input kind, input tx_byte, input red, input green,
		input blue, input last, output ready);
endinterface

>>> sv/scld_front.sv
module scld_front (
	scld_item_if.sink     item,
	input  logic          push_ready,
	output logic          push_valid,
	output scld_pkg::op_t push_op
);
	import scld_pkg::*;

	assign item.ready = push_ready;
	assign push_valid = item.valid;

	// sort the incoming word into its class
	always_comb begin
		push_op.data = item.rx_byte;
		if (item.cmd)
			push_op.cls = OP_FLUSH;
		else if (item.rx_byte == CH_CR || item.rx_byte == CH_LF)
			push_op.cls = OP_EOL;
		else if (item.rx_byte == CH_BS || item.rx_byte == CH_DEL)
			push_op.cls = OP_BS;
		else
			push_op.cls = OP_CHAR;
	end

endmodule

>>> sv/scld_queue.sv
module scld_queue #(
	parameter int DEPTH = scld_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	input  scld_pkg::op_t push_op,
	output logic          push_ready,
	output logic          pop_valid,
	output scld_pkg::op_t pop_op,
	input  logic          pop
);
	import scld_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	op_t              entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_op     = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_op;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> sv/scld_back.sv
module scld_back #(
	parameter int LINE_BYTES = scld_pkg::LINE_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [7:0]    cfg_wdata,
	input  logic          op_valid,
	input  scld_pkg::op_t op,
	output logic          op_pop,
	scld_result_if.source result
);
	import scld_pkg::*;

	localparam int LEN_W = $clog2(LINE_BYTES);

	logic [7:0]       level_q;
	logic [LEN_W-1:0] len_q;
	line_head_t       head_q;
	logic [1:0]       step_q;

	logic             out_valid_q;
	kind_t            kind_q;
	logic [7:0]       tx_q;
	logic [7:0]       red_q;
	logic [7:0]       green_q;
	logic [7:0]       blue_q;
	logic             last_q;

	logic [LEN_W:0]   len_x;
	logic [3:0]       len_sat;
	logic             len_nz;
	logic [1:0]       last_step;
	logic             slot_free;
	logic             emit;
	logic             is_last;
	kind_t            kind_d;
	logic [7:0]       tx_d;
	logic [7:0]       red_d;
	logic [7:0]       green_d;
	logic [7:0]       blue_d;

	assign len_x   = {1'b0, len_q};
	assign len_sat = (len_x >= (LEN_W + 1)'(HEAD_BYTES)) ? 4'(HEAD_BYTES) : 4'(len_x);
	assign len_nz  = (len_q != '0);

	// results for this word: echo, then, if the line is not empty, line feed and verdict or the erase triple
	always_comb begin
		unique case (op.cls)
			OP_EOL:  last_step = len_nz ? 2'd2 : 2'd0;
			OP_BS:   last_step = len_nz ? 2'd3 : 2'd0;
			default: last_step = 2'd0;
		endcase
	end

	assign slot_free = !out_valid_q || result.ready;
	assign emit      = op_valid && (op.cls != OP_FLUSH) && slot_free;
	assign is_last   = (step_q == last_step);
	assign op_pop    = op_valid && ((op.cls == OP_FLUSH) || (emit && is_last));

	// result for the current step
	always_comb begin
		kind_d  = KIND_ECHO;
		tx_d    = op.data;
		red_d   = 8'h00;
		green_d = 8'h00;
		blue_d  = 8'h00;
		if (step_q != 2'd0) begin
			if (op.cls == OP_EOL) begin
				if (step_q == 2'd1) begin
					tx_d = CH_LF;
				end else begin
					// line verdict
					tx_d = 8'h00;
					kind_d = KIND_COLOUR;
					priority if (kw_hit(head_q, KW_ON, KW_ON_LEN, len_sat)) begin
						red_d = level_q;
						green_d = level_q;
						blue_d = level_q;
					end else if (kw_hit(head_q, KW_OFF, KW_OFF_LEN, len_sat)) begin
						red_d = 8'h00;
					end else if (kw_hit(head_q, KW_RED, KW_RED_LEN, len_sat)) begin
						red_d = level_q;
					end else if (kw_hit(head_q, KW_GREEN, KW_GREEN_LEN, len_sat)) begin
						green_d = level_q;
					end else if (kw_hit(head_q, KW_BLUE, KW_BLUE_LEN, len_sat)) begin
						blue_d = level_q;
					end else begin
						kind_d = KIND_UNKNOWN;
					end
				end
			end else begin
				tx_d = (step_q == 2'd2) ? CH_SPACE : CH_BS;
			end
		end
	end

	// level register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			level_q <= LEVEL_RESET;
		else if (cfg_we)
			level_q <= cfg_wdata;
	end

	// step counter and line length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 2'd0;
			len_q  <= '0;
		end else begin
			if (op_pop)
				step_q <= 2'd0;
			else if (emit)
				step_q <= step_q + 2'd1;
			if (op_pop) begin
				unique case (op.cls)
					OP_FLUSH: len_q <= '0;
					OP_EOL:   len_q <= '0;
					OP_BS:    if (len_nz) len_q <= len_q - 1'b1;
					OP_CHAR:  if (len_q < LEN_W'(LINE_BYTES - 1)) len_q <= len_q + 1'b1;
				endcase
			end
		end
	end

	// head bytes of the line; later bytes never reach the verdict
	always_ff @(posedge clk) begin
		if (op_pop && op.cls == OP_CHAR && len_x < (LEN_W + 1)'(HEAD_BYTES)
				&& len_q < LEN_W'(LINE_BYTES - 1))
			head_q[len_q[2:0]] <= op.data;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q  <= kind_d;
			tx_q    <= tx_d;
			red_q   <= red_d;
			green_q <= green_d;
			blue_q  <= blue_d;
			last_q  <= is_last;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.kind    = kind_q;
	assign result.tx_byte = tx_q;
	assign result.red     = red_q;
	assign result.green   = green_q;
	assign result.blue    = blue_q;
	assign result.last    = last_q;

	// checks
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(LINE_BYTES - 1))
		else $error("line length beyond capacity");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		op_valid |-> step_q <= last_step)
		else $error("step counter ran past the last result");

	a_eol_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(op_pop && op.cls == OP_EOL) |=> len_q == '0)
		else $error("line not cleared after line end");

	a_bs_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(op_pop && op.cls == OP_BS && len_nz) |=> len_q == $past(len_q) - 1'b1)
		else $error("erase did not shorten the line");

	a_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!op_valid |-> step_q == 2'd0)
		else $error("step counter busy with no word pending");

endmodule

>>> sv/serial_command_line_decoder.sv
// Channel   Dir  Fields                                   Word accepted when
// item      in   cmd, rx_byte                             item.valid && item.ready
// result    out  kind, tx_byte, red, green, blue, last    result.valid && result.ready
// cfg       in   cfg_wdata (level)                        cfg_we
//
// Each input word yields 1 to 4 results, one per cycle from the output register while results are taken.
// A flush word clears the line in the back end and yields nothing.
// The classify queue takes new words while the back end is still emitting results.
// Reset clears line length, queue and output; level returns to 16.
// A stalled result holds the back end; the front keeps accepting until the queue fills.
module serial_command_line_decoder #(
	parameter int LINE_BYTES  = scld_pkg::LINE_BYTES_DEF,
	parameter int QUEUE_DEPTH = scld_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	scld_item_if.sink  item,
	scld_result_if.source result,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);
	import scld_pkg::*;

	logic push_valid;
	logic push_ready;
	op_t  push_op;
	logic pop_valid;
	op_t  pop_op;
	logic pop;

	scld_front u_front (
		.item       (item),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_op    (push_op)
	);

	scld_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_op    (push_op),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_op     (pop_op),
		.pop        (pop)
	);

	scld_back #(.LINE_BYTES(LINE_BYTES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.op_valid  (pop_valid),
		.op        (pop_op),
		.op_pop    (pop),
		.result    (result)
	);

endmodule
